/* hw/rtl/pre_pkg.sv */
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and constants of the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

  // Width of the min_length register.
  localparam int unsigned CFG_W = 7;

  // Printable characters lie in [CHAR_FIRST, CHAR_END).
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_END   = 8'h7F;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // take the input byte and update the run state
    logic flush_rd;    // read the next held character from the buffer
    logic flush_emit;  // load the read character into the output register
    logic end_emit;    // load an end-of-string marker into the output register
  } pre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a new item this cycle
    logic start_flush;  // the current input byte starts a buffer flush
    logic flush_last;   // the character being flushed is the last held one
    logic term_pending; // an end marker follows the flush
  } pre_status_t;

endpackage

/* hw/rtl/pre_ctrl.sv */
// ----------------------------------------------------------------------------
// pre_ctrl
// Sequencer for the printable run extractor: takes bytes, steps through the
// buffer flush and emits the end-of-string marker.
// ----------------------------------------------------------------------------
module pre_ctrl
  import pre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pre_status_t status_i,
  output pre_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_FLUSH_RD = 2'd1;
  localparam logic [1:0] S_FLUSH_WR = 2'd2;
  localparam logic [1:0] S_END      = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (status_i.start_flush) begin
            state_d = S_FLUSH_RD;
          end
        end
      end
      S_FLUSH_RD: begin
        cmd_o.flush_rd = 1'b1;
        state_d        = S_FLUSH_WR;
      end
      S_FLUSH_WR: begin
        if (status_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          if (!status_i.flush_last) begin
            state_d = S_FLUSH_RD;
          end else if (status_i.term_pending) begin
            state_d = S_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_END: begin
        if (status_i.out_free) begin
          cmd_o.end_emit = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/pre_datapath.sv */
// ----------------------------------------------------------------------------
// pre_datapath
// Byte classification, run state, hold buffer and output register of the
// printable run extractor.
// ----------------------------------------------------------------------------
module pre_datapath
  import pre_pkg::*;
#(
  parameter int unsigned MAX_MIN_LENGTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] min_length_i,
  input  logic             alnum_only_i,
  input  logic [7:0]       data_byte_i,
  input  pre_cmd_t         cmd_i,
  output pre_status_t      status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             is_end_o,
  output logic             last_o
);

  localparam int unsigned CW = $clog2(MAX_MIN_LENGTH + 1);
  localparam int unsigned AW = (MAX_MIN_LENGTH > 1) ? $clog2(MAX_MIN_LENGTH) : 1;
  localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_MIN_LENGTH);
  localparam logic [CFG_W-1:0] MAX_LIM = CFG_W'(MAX_MIN_LENGTH);

  logic [7:0]    mem_q [MAX_MIN_LENGTH];
  logic [7:0]    rdata_q;
  logic [CW-1:0] count_q, count_d;
  logic          qual_q, qual_d;
  logic [CW-1:0] flen_q, flen_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          term_q, term_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          is_end_q, is_end_d;
  logic          last_q, last_d;

  logic             printable, alnum, keep;
  logic [CFG_W-1:0] lim;
  logic [CW-1:0]    count_inc;
  logic             pass_char, emit_end, start_flush, flush_last, out_free, mem_wr;

  always_comb begin
    printable = (data_byte_i >= CHAR_FIRST) && (data_byte_i < CHAR_END);
    alnum = ((data_byte_i >= 8'h61) && (data_byte_i <= 8'h7A)) ||
            ((data_byte_i >= 8'h41) && (data_byte_i <= 8'h5A)) ||
            ((data_byte_i >= 8'h30) && (data_byte_i <= 8'h39));
    keep  = printable && !(alnum_only_i && !alnum);
    lim   = (min_length_i > MAX_LIM) ? MAX_LIM : min_length_i;
    // The held count saturates at the buffer depth.
    count_inc = (count_q < MAX_CNT) ? count_q + CW'(1) : count_q;
    pass_char = keep && qual_q;
    emit_end  = !printable && qual_q;
    start_flush = (keep && !qual_q && (CFG_W'(count_inc) >= lim)) ||
                  (!printable && !qual_q && (count_q != '0) &&
                   (CFG_W'(count_q) >= lim));
    flush_last = ((idx_q + CW'(1)) == flen_q);
    out_free   = !out_valid_q || out_ready_i;
    mem_wr     = cmd_i.accept && keep && !qual_q && (count_q < MAX_CNT);
  end

  assign status_o.out_free     = out_free;
  assign status_o.start_flush  = start_flush;
  assign status_o.flush_last   = flush_last;
  assign status_o.term_pending = term_q;

  // Run state.
  always_comb begin
    count_d = count_q;
    qual_d  = qual_q;
    flen_d  = flen_q;
    idx_d   = idx_q;
    term_d  = term_q;
    if (cmd_i.accept) begin
      if (keep && !qual_q) begin
        if (start_flush) begin
          count_d = '0;
          qual_d  = 1'b1;
          flen_d  = count_inc;
          idx_d   = '0;
          term_d  = 1'b0;
        end else begin
          count_d = count_inc;
        end
      end else if (!printable) begin
        count_d = '0;
        qual_d  = 1'b0;
        if (start_flush) begin
          flen_d = count_q;
          idx_d  = '0;
          term_d = 1'b1;
        end
      end
    end else if (cmd_i.flush_emit) begin
      idx_d = idx_q + CW'(1);
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    is_end_d    = is_end_q;
    last_d      = last_q;
    if (cmd_i.accept && pass_char) begin
      out_valid_d = 1'b1;
      out_char_d  = data_byte_i;
      is_end_d    = 1'b0;
      last_d      = 1'b1;
    end else if ((cmd_i.accept && emit_end) || cmd_i.end_emit) begin
      out_valid_d = 1'b1;
      out_char_d  = '0;
      is_end_d    = 1'b1;
      last_d      = 1'b1;
    end else if (cmd_i.flush_emit) begin
      out_valid_d = 1'b1;
      out_char_d  = rdata_q;
      is_end_d    = 1'b0;
      last_d      = flush_last && !term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      qual_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      qual_q      <= qual_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q     <= flen_d;
    idx_q      <= idx_d;
    term_q     <= term_d;
    out_char_q <= out_char_d;
    is_end_q   <= is_end_d;
    last_q     <= last_d;
  end

  // Hold buffer with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[count_q[AW-1:0]] <= data_byte_i;
    end
    if (cmd_i.flush_rd) begin
      rdata_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign is_end_o    = is_end_q;
  assign last_o      = last_q;

endmodule

/* hw/rtl/printable_run_extractor_core.sv */
// Printable run extractor. Each input item is one raw byte; result items are
// the characters of printable runs that reach min_length (only alphanumeric
// ones under alnum_only), each followed by an end-of-string marker when a
// non-printable byte closes the run. A byte that causes no flush is taken in
// the idle state, also when it passes a character straight through. A byte
// that qualifies a run starts a flush that takes no new byte: every held
// character is read from the hold buffer through its registered read port
// before it is loaded into the output register; a closing byte then adds
// the end marker. The hold buffer needs no clearing after reset, so bytes are
// taken at once. Output stalls hold the block in place.
// ----------------------------------------------------------------------------
// printable_run_extractor_core
// Top level: configuration registers on an APB-style port, controller and
// datapath.
// ----------------------------------------------------------------------------
module printable_run_extractor_core
  import pre_pkg::*;
#(
  parameter int unsigned MAX_MIN_LENGTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        is_end_o,
  output logic        last_o
);

  localparam logic REG_MIN_LENGTH = 1'b0;
  localparam logic REG_ALNUM_ONLY = 1'b1;

  logic [CFG_W-1:0] min_length_q;
  logic             alnum_only_q;
  logic             cfg_wr;
  pre_cmd_t         cmd;
  pre_status_t      status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= '0;
      alnum_only_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MIN_LENGTH: min_length_q <= pwdata[CFG_W-1:0];
        REG_ALNUM_ONLY: alnum_only_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_LENGTH: prdata = {{(32 - CFG_W){1'b0}}, min_length_q};
      REG_ALNUM_ONLY: prdata = {31'b0, alnum_only_q};
      default:        prdata = '0;
    endcase
  end

  pre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pre_datapath #(
    .MAX_MIN_LENGTH (MAX_MIN_LENGTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_length_i (min_length_q),
    .alnum_only_i (alnum_only_q),
    .data_byte_i  (data_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .is_end_o     (is_end_o),
    .last_o       (last_o)
  );

endmodule

/* hw/rtl/pre_checker.sv */
// ----------------------------------------------------------------------------
// pre_checker
// Port-level checks of the printable run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module pre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       is_end_i,
  input logic       last_i
);

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_char_i) && $stable(is_end_i) && $stable(last_i))
    else $error("result payload changed while stalled");

  // An end marker carries a zero character and closes the item's results.
  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |-> (out_char_i == 8'h00) && last_i)
    else $error("malformed end marker");

  // Characters of a run are always printable.
  a_char_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_end_i |-> (out_char_i >= 8'h20) && (out_char_i < 8'h7F))
    else $error("non-printable character in a run");

  // No byte is taken while the output register is full and stalled.
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while the output is stalled");

endmodule

bind printable_run_extractor_core pre_checker u_pre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_i  (out_char_o),
  .is_end_i    (is_end_o),
  .last_i      (last_o)
);
